### src/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types and constants for the banker's deadlock-avoidance engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bda_pkg;

    localparam int DEF_MAX_PROCS     = 16;
    localparam int DEF_MAX_RESOURCES = 8;

    localparam int VALUE_W   = 16;
    localparam int OP_W      = 3;
    localparam int PROC_W    = 4;
    localparam int RES_W     = 3;
    localparam int KIND_W    = 3;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCS_IN_USE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESOURCES_IN_USE = 1'b1;

    localparam logic [4:0] PROCS_RESET     = 5'd16;
    localparam logic [3:0] RESOURCES_RESET = 4'd8;

    typedef enum logic [OP_W-1:0] {
        OP_WR_ALLOC = 3'd0,
        OP_WR_MAX   = 3'd1,
        OP_WR_AVAIL = 3'd2,
        OP_REQUEST  = 3'd3,
        OP_CHECK    = 3'd4
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_SEQ    = 3'd0,
        KIND_SAFE   = 3'd1,
        KIND_UNSAFE = 3'd2,
        KIND_GRANT  = 3'd3,
        KIND_DENY   = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REQ_RD,
        S_REQ_CMP,
        S_GNT_RD,
        S_GNT_WR,
        S_REQ_OUT,
        S_CHK_SCAN,
        S_CHK_RD,
        S_CHK_CMP,
        S_ADD_RD,
        S_ADD_WR,
        S_SEQ_OUT,
        S_CHK_NEXT,
        S_VERDICT_OUT
    } state_t;

    function automatic logic [VALUE_W-1:0] sat_add(input logic [VALUE_W-1:0] a,
                                                  input logic [VALUE_W-1:0] b);
        logic [VALUE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VALUE_W] ? {VALUE_W{1'b1}} : s[VALUE_W-1:0];
    endfunction

endpackage

`default_nettype wire

### src/bankers_deadlock_avoidance.sv
// ----------------------------------------------------------------------------
// bankers_deadlock_avoidance
// Banker's algorithm engine: matrix loads, request grant check, safety check.
// ----------------------------------------------------------------------------
// Usage: items enter on s_* (valid/ready). Ops: write allocation, write
// maximum claim, write available, request element, safety check. Results
// leave on m_* (valid/ready) through a single output register; the block
// takes the next item while a result still waits there.
// Loads and non-last request elements give no result. A last request
// element compares the buffered request with need and with available for
// each resource in use, stopping at the first that fails; if all pass, a
// grant write-back adds the request to the allocation and takes it from
// available; the verdict is then posted. Both passes step through the
// allocation and claim RAMs one entry at a time through their single read
// port, with registered read data. A safety check visits each unfinished
// process per pass, comparing its need with the work vector and on a fit
// adding its allocation to it; passes repeat while any process finishes.
// Reset clears control, the request buffer, work vector and finished flags;
// the matrices and available vector hold nothing until written.
// A stalled receiver holds the engine in the state that posts a result.
// ----------------------------------------------------------------------------
`default_nettype none

module bankers_deadlock_avoidance #(
    parameter int MAX_PROCS     = bda_pkg::DEF_MAX_PROCS,
    parameter int MAX_RESOURCES = bda_pkg::DEF_MAX_RESOURCES
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           cfg_wr_en,
    input  wire logic [bda_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bda_pkg::CFG_W-1:0]      cfg_wdata,

    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [bda_pkg::OP_W-1:0]       s_op,
    input  wire logic [bda_pkg::PROC_W-1:0]     s_process,
    input  wire logic [bda_pkg::RES_W-1:0]      s_resource,
    input  wire logic [bda_pkg::VALUE_W-1:0]    s_value,
    input  wire logic                           s_last,

    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [bda_pkg::KIND_W-1:0]          m_kind,
    output logic [bda_pkg::PROC_W-1:0]          m_process_res,
    output logic                                m_final_res
);

    localparam int VW    = bda_pkg::VALUE_W;
    localparam int DEPTH = MAX_PROCS * MAX_RESOURCES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PIW   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int RIW   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int PCW   = $clog2(MAX_PROCS + 1) + 1;
    localparam int RCW   = $clog2(MAX_RESOURCES + 1) + 1;

    bda_pkg::state_t state_reg, state_next;

    logic [4:0]           procs_cfg_reg;
    logic [3:0]           res_cfg_reg;
    logic [PCW-1:0]       np;
    logic [RCW-1:0]       nr;

    logic [VW-1:0]        avail_reg [MAX_RESOURCES];
    logic [VW-1:0]        reqbuf_reg [MAX_RESOURCES];
    logic [VW-1:0]        work_reg [MAX_RESOURCES];
    logic [MAX_PROCS-1:0] fin_reg;
    logic [PCW-1:0]       done_reg;
    logic                 prog_reg;
    logic [PIW-1:0]       q_reg;
    logic [RIW-1:0]       s_reg;
    logic [bda_pkg::PROC_W-1:0] p_reg;
    logic                 grant_reg;

    logic                 m_valid_reg;
    logic [bda_pkg::KIND_W-1:0] m_kind_reg;
    logic [bda_pkg::PROC_W-1:0] m_process_res_reg;
    logic                 m_final_res_reg;

    logic                 accept;
    logic                 out_free;
    logic                 out_load;
    logic                 s_pok, s_rok;
    logic                 s_last_res;
    logic                 q_last;
    logic [AW-1:0]        wr_addr_in;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        cur_addr;
    logic [PIW-1:0]       row_idx;

    logic                 alloc_we, max_we;
    logic [AW-1:0]        alloc_waddr;
    logic [VW-1:0]        alloc_wdata;
    logic [VW-1:0]        alloc_rdata, max_rdata;

    logic signed [VW+1:0] need;
    logic signed [VW+1:0] rq_s, work_s;
    logic [VW-1:0]        alloc_sum;
    logic [VW-1:0]        work_sum;

    // effective register values, saturated into range
    always_comb begin
        if (procs_cfg_reg == '0) begin
            np = PCW'(1);
        end else if (32'(procs_cfg_reg) > MAX_PROCS) begin
            np = PCW'(MAX_PROCS);
        end else begin
            np = PCW'(procs_cfg_reg);
        end
        if (res_cfg_reg == '0) begin
            nr = RCW'(1);
        end else if (32'(res_cfg_reg) > MAX_RESOURCES) begin
            nr = RCW'(MAX_RESOURCES);
        end else begin
            nr = RCW'(res_cfg_reg);
        end
    end

    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign out_load   = out_free && (state_reg == bda_pkg::S_REQ_OUT
                                     || state_reg == bda_pkg::S_SEQ_OUT
                                     || state_reg == bda_pkg::S_VERDICT_OUT);
    assign s_pok      = 32'(s_process) < MAX_PROCS;
    assign s_rok      = 32'(s_resource) < MAX_RESOURCES;
    assign s_last_res = (RCW'(s_reg) == nr - RCW'(1));
    assign q_last     = (PCW'(q_reg) == np - PCW'(1));

    assign wr_addr_in = AW'(AW'(s_process) * AW'(MAX_RESOURCES) + AW'(s_resource));
    assign row_idx    = (state_reg == bda_pkg::S_REQ_RD || state_reg == bda_pkg::S_GNT_RD
                         || state_reg == bda_pkg::S_REQ_CMP || state_reg == bda_pkg::S_GNT_WR)
                        ? PIW'(p_reg) : q_reg;
    assign cur_addr   = AW'(AW'(row_idx) * AW'(MAX_RESOURCES) + AW'(s_reg));
    assign rd_addr    = cur_addr;

    // reads and write-backs walk distinct entries, so no forwarding is needed
    assign alloc_sum  = bda_pkg::sat_add(alloc_rdata, reqbuf_reg[s_reg]);
    assign work_sum   = bda_pkg::sat_add(work_reg[s_reg], alloc_rdata);
    assign need       = $signed({2'b00, max_rdata}) - $signed({2'b00, alloc_rdata});
    assign rq_s       = $signed({2'b00, reqbuf_reg[s_reg]});
    assign work_s     = $signed({2'b00, work_reg[s_reg]});

    always_comb begin
        alloc_we    = 1'b0;
        max_we      = 1'b0;
        alloc_waddr = wr_addr_in;
        alloc_wdata = s_value;
        if (state_reg == bda_pkg::S_GNT_WR) begin
            alloc_we    = 1'b1;
            alloc_waddr = cur_addr;
            alloc_wdata = alloc_sum;
        end else if (accept && s_pok && s_rok) begin
            alloc_we = (s_op == bda_pkg::OP_WR_ALLOC);
            max_we   = (s_op == bda_pkg::OP_WR_MAX);
        end
    end

    bda_ram #(.WIDTH(VW), .DEPTH(DEPTH), .AW(AW)) u_alloc_ram (
        .aclk  (aclk),
        .we    (alloc_we),
        .waddr (alloc_waddr),
        .wdata (alloc_wdata),
        .raddr (rd_addr),
        .rdata (alloc_rdata)
    );

    bda_ram #(.WIDTH(VW), .DEPTH(DEPTH), .AW(AW)) u_max_ram (
        .aclk  (aclk),
        .we    (max_we),
        .waddr (wr_addr_in),
        .wdata (s_value),
        .raddr (rd_addr),
        .rdata (max_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bda_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            bda_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_op == bda_pkg::OP_REQUEST && s_last) begin
                        if (s_pok && 32'(s_process) < 32'(np)) begin
                            state_next = bda_pkg::S_REQ_RD;
                        end else begin
                            state_next = bda_pkg::S_REQ_OUT;
                        end
                    end else if (s_op == bda_pkg::OP_CHECK) begin
                        state_next = bda_pkg::S_CHK_SCAN;
                    end
                end
            end
            bda_pkg::S_REQ_RD:  state_next = bda_pkg::S_REQ_CMP;
            bda_pkg::S_REQ_CMP: begin
                if (rq_s > need || reqbuf_reg[s_reg] > avail_reg[s_reg]) begin
                    state_next = bda_pkg::S_REQ_OUT;
                end else if (s_last_res) begin
                    state_next = bda_pkg::S_GNT_RD;
                end else begin
                    state_next = bda_pkg::S_REQ_RD;
                end
            end
            bda_pkg::S_GNT_RD:  state_next = bda_pkg::S_GNT_WR;
            bda_pkg::S_GNT_WR: begin
                state_next = s_last_res ? bda_pkg::S_REQ_OUT : bda_pkg::S_GNT_RD;
            end
            bda_pkg::S_REQ_OUT: begin
                if (out_free) begin
                    state_next = bda_pkg::S_IDLE;
                end
            end
            bda_pkg::S_CHK_SCAN: begin
                state_next = fin_reg[q_reg] ? bda_pkg::S_CHK_NEXT : bda_pkg::S_CHK_RD;
            end
            bda_pkg::S_CHK_RD:  state_next = bda_pkg::S_CHK_CMP;
            bda_pkg::S_CHK_CMP: begin
                // negative need never exceeds the work count
                if (need > work_s) begin
                    state_next = bda_pkg::S_CHK_NEXT;
                end else if (s_last_res) begin
                    state_next = bda_pkg::S_ADD_RD;
                end else begin
                    state_next = bda_pkg::S_CHK_RD;
                end
            end
            bda_pkg::S_ADD_RD:  state_next = bda_pkg::S_ADD_WR;
            bda_pkg::S_ADD_WR: begin
                state_next = s_last_res ? bda_pkg::S_SEQ_OUT : bda_pkg::S_ADD_RD;
            end
            bda_pkg::S_SEQ_OUT: begin
                if (out_free) begin
                    state_next = bda_pkg::S_CHK_NEXT;
                end
            end
            bda_pkg::S_CHK_NEXT: begin
                if (q_last && !prog_reg) begin
                    state_next = bda_pkg::S_VERDICT_OUT;
                end else begin
                    state_next = bda_pkg::S_CHK_SCAN;
                end
            end
            bda_pkg::S_VERDICT_OUT: begin
                if (out_free) begin
                    state_next = bda_pkg::S_IDLE;
                end
            end
            default: state_next = bda_pkg::S_IDLE;
        endcase
    end

    // datapath and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            procs_cfg_reg <= bda_pkg::PROCS_RESET;
            res_cfg_reg   <= bda_pkg::RESOURCES_RESET;
            for (int i = 0; i < MAX_RESOURCES; i++) begin
                reqbuf_reg[i] <= '0;
                work_reg[i]   <= '0;
            end
            fin_reg     <= '0;
            done_reg    <= '0;
            prog_reg    <= 1'b0;
            q_reg       <= '0;
            s_reg       <= '0;
            grant_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == bda_pkg::CFG_PROCS_IN_USE) begin
                    procs_cfg_reg <= cfg_wdata;
                end else begin
                    res_cfg_reg <= cfg_wdata[3:0];
                end
            end

            if (m_valid_reg && m_ready && !out_load) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                bda_pkg::S_IDLE: begin
                    if (accept) begin
                        p_reg     <= s_process;
                        s_reg     <= '0;
                        q_reg     <= '0;
                        grant_reg <= 1'b0;
                        if (s_op == bda_pkg::OP_WR_AVAIL && s_rok) begin
                            avail_reg[RIW'(s_resource)] <= s_value;
                        end
                        if (s_op == bda_pkg::OP_REQUEST && s_rok) begin
                            reqbuf_reg[RIW'(s_resource)] <= s_value;
                        end
                        if (s_op == bda_pkg::OP_CHECK) begin
                            for (int i = 0; i < MAX_RESOURCES; i++) begin
                                work_reg[i] <= avail_reg[i];
                            end
                            fin_reg  <= '0;
                            done_reg <= '0;
                            prog_reg <= 1'b0;
                        end
                    end
                end
                bda_pkg::S_REQ_CMP: begin
                    if (!(rq_s > need || reqbuf_reg[s_reg] > avail_reg[s_reg])) begin
                        s_reg <= s_last_res ? '0 : s_reg + RIW'(1);
                    end
                end
                bda_pkg::S_GNT_WR: begin
                    avail_reg[s_reg] <= avail_reg[s_reg] - reqbuf_reg[s_reg];
                    grant_reg        <= 1'b1;
                    s_reg            <= s_reg + RIW'(1);
                end
                bda_pkg::S_REQ_OUT: begin
                    if (out_free) begin
                        m_valid_reg       <= 1'b1;
                        m_kind_reg        <= grant_reg ? bda_pkg::KIND_GRANT
                                                       : bda_pkg::KIND_DENY;
                        m_process_res_reg <= '0;
                        m_final_res_reg   <= 1'b1;
                        for (int i = 0; i < MAX_RESOURCES; i++) begin
                            reqbuf_reg[i] <= '0;
                        end
                    end
                end
                bda_pkg::S_CHK_CMP: begin
                    if (!(need > work_s)) begin
                        s_reg <= s_last_res ? '0 : s_reg + RIW'(1);
                    end
                end
                bda_pkg::S_ADD_WR: begin
                    work_reg[s_reg] <= work_sum;
                    s_reg           <= s_reg + RIW'(1);
                end
                bda_pkg::S_SEQ_OUT: begin
                    if (out_free) begin
                        m_valid_reg       <= 1'b1;
                        m_kind_reg        <= bda_pkg::KIND_SEQ;
                        m_process_res_reg <= bda_pkg::PROC_W'(q_reg);
                        m_final_res_reg   <= 1'b0;
                        fin_reg[q_reg]    <= 1'b1;
                        done_reg          <= done_reg + PCW'(1);
                        prog_reg          <= 1'b1;
                    end
                end
                bda_pkg::S_CHK_NEXT: begin
                    s_reg <= '0;
                    if (q_last) begin
                        q_reg    <= '0;
                        prog_reg <= 1'b0;
                    end else begin
                        q_reg <= q_reg + PIW'(1);
                    end
                end
                bda_pkg::S_VERDICT_OUT: begin
                    if (out_free) begin
                        m_valid_reg       <= 1'b1;
                        m_kind_reg        <= (done_reg == np) ? bda_pkg::KIND_SAFE
                                                              : bda_pkg::KIND_UNSAFE;
                        m_process_res_reg <= '0;
                        m_final_res_reg   <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_process_res = m_process_res_reg;
    assign m_final_res   = m_final_res_reg;

    // a sequence entry is never the closing result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == bda_pkg::KIND_SEQ) |-> !m_final_res)
        else $error("sequence entry marked final");

    // finished count stays within the processes in use
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bda_pkg::S_VERDICT_OUT) |-> (done_reg <= np))
        else $error("finished count exceeds processes in use");

    // a process is reported at most once per check
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bda_pkg::S_SEQ_OUT) |-> !fin_reg[q_reg])
        else $error("process reported twice");

    // a result is loaded only into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_kind) && $stable(m_process_res)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

### src/bda_ram.sv
// ----------------------------------------------------------------------------
// bda_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bda_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the banker's deadlock-avoidance engine: loads the
// matrices, drives request vectors and safety checks under random flow
// control and directed register settings, and compares every result item with an
// in-bench prediction of grants, finishing order and verdicts.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    typedef struct {
        bda_pkg::kind_t kind;
        logic [3:0]     proc_id;
        logic           fin;
    } verdict_t;

    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [4:0]  cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_op = '0;
    logic [3:0]  s_process = '0;
    logic [2:0]  s_resource = '0;
    logic [15:0] s_value = '0;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_kind;
    logic [3:0]  m_process_res;
    logic        m_final_res;

    // predictor state
    logic [15:0] alloc_units [16][8];
    logic [15:0] claim_units [16][8];
    logic [15:0] avail_units [8];
    logic [15:0] req_units [8];
    logic [4:0]  procs_reg = 5'd16;
    logic [3:0]  res_reg = 4'd8;

    verdict_t    pending_results[$];
    bit          failed = 0;
    int          burst_left = 0;
    int          hold_left = 0;
    bit          hold_request = 0;
    bit          hold_taken = 0;
    int          stall_mode = 0;
    int          mode_cnt = 0;

    bankers_deadlock_avoidance dut (.*);

    always #5 aclk = ~aclk;

    initial begin
        #100_000_000;
        $display("Verification failed");
        $finish;
    end

    // receiver: long hold-off on request, otherwise a changing stall pattern
    always @(negedge aclk) begin
        if (hold_request && !hold_taken) begin
            hold_left = 400;
            hold_taken = 1;
        end
        if (mode_cnt == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_cnt = $urandom_range(20, 120);
        end
        mode_cnt = mode_cnt - 1;
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (stall_mode == 0) begin
            m_ready <= 1'b1;
        end else if (stall_mode == 1) begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end else begin
            m_ready <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge aclk) begin
        verdict_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected: kind %0d", m_kind);
                failed = 1;
            end else begin
                e = pending_results.pop_front();
                if (m_kind != e.kind) begin
                    $error("kind: expected %0d, actual %0d", e.kind, m_kind);
                    failed = 1;
                end
                if (m_process_res != e.proc_id) begin
                    $error("process_res: expected %0d, actual %0d", e.proc_id,
                           m_process_res);
                    failed = 1;
                end
                if (m_final_res != e.fin) begin
                    $error("final_res: expected %0d, actual %0d", e.fin, m_final_res);
                    failed = 1;
                end
            end
        end
    end

    function automatic int procs_eff();
        return (procs_reg < 1) ? 1 : (procs_reg > 16) ? 16 : int'(procs_reg);
    endfunction

    function automatic int res_eff();
        return (res_reg < 1) ? 1 : (res_reg > 8) ? 8 : int'(res_reg);
    endfunction

    function automatic int need_of(int p, int r);
        return int'(claim_units[p][r]) - int'(alloc_units[p][r]);
    endfunction

    function automatic logic [15:0] add_sat(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic void push_result(bda_pkg::kind_t k, logic [3:0] p, logic f);
        verdict_t e;
        e.kind = k;
        e.proc_id = p;
        e.fin = f;
        pending_results.push_back(e);
    endfunction

    function automatic void predict_safety();
        logic [15:0] work [8];
        logic [15:0] done_mask;
        int          np, nr, finished;
        bit          progress, fits;
        np = procs_eff();
        nr = res_eff();
        work = avail_units;
        done_mask = '0;
        finished = 0;
        progress = 1;
        while (progress) begin
            progress = 0;
            for (int q = 0; q < np; q++) begin
                if (!done_mask[q]) begin
                    fits = 1;
                    for (int s = 0; s < nr; s++)
                        if (need_of(q, s) > int'(work[s])) fits = 0;
                    if (fits) begin
                        for (int s = 0; s < nr; s++)
                            work[s] = add_sat(work[s], alloc_units[q][s]);
                        done_mask[q] = 1'b1;
                        finished++;
                        progress = 1;
                        push_result(bda_pkg::KIND_SEQ, q[3:0], 1'b0);
                    end
                end
            end
        end
        push_result(finished == np ? bda_pkg::KIND_SAFE : bda_pkg::KIND_UNSAFE,
                    4'd0, 1'b1);
    endfunction

    function automatic void predict_item(logic [2:0] op, logic [3:0] p, logic [2:0] r,
                                         logic [15:0] v, logic last);
        bit ok;
        int nr;
        nr = res_eff();
        case (op)
            bda_pkg::OP_WR_ALLOC: alloc_units[p][r] = v;
            bda_pkg::OP_WR_MAX:   claim_units[p][r] = v;
            bda_pkg::OP_WR_AVAIL: avail_units[r] = v;
            bda_pkg::OP_REQUEST: begin
                req_units[r] = v;
                if (last) begin
                    ok = (int'(p) < procs_eff());
                    for (int s = 0; s < nr; s++)
                        if (ok && (int'(req_units[s]) > need_of(p, s) ||
                                   req_units[s] > avail_units[s])) ok = 0;
                    if (ok) begin
                        for (int s = 0; s < nr; s++) begin
                            avail_units[s] = avail_units[s] - req_units[s];
                            alloc_units[p][s] = add_sat(alloc_units[p][s], req_units[s]);
                        end
                    end
                    foreach (req_units[s]) req_units[s] = '0;
                    push_result(ok ? bda_pkg::KIND_GRANT : bda_pkg::KIND_DENY, 4'd0, 1'b1);
                end
            end
            bda_pkg::OP_CHECK: predict_safety();
            default: ;
        endcase
    endfunction

    task automatic send_item(logic [2:0] op, logic [3:0] p, logic [2:0] r,
                             logic [15:0] v, logic last);
        if (burst_left == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
        end
        burst_left--;
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_op       <= op;
        s_process  <= p;
        s_resource <= r;
        s_value    <= v;
        s_last     <= last;
        do @(posedge aclk); while (!s_ready);
        predict_item(op, p, r, v, last);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [4:0] data);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == bda_pkg::CFG_PROCS_IN_USE) procs_reg = data;
        else res_reg = data[3:0];
    endtask

    // full request vector over the resources in use, elements in random order
    task automatic send_request(logic [3:0] p, int max_val);
        int nr, order [8];
        nr = res_eff();
        for (int s = 0; s < 8; s++) order[s] = s;
        for (int s = nr - 1; s > 0; s--) begin
            int j, t;
            j = $urandom_range(0, s);
            t = order[s]; order[s] = order[j]; order[j] = t;
        end
        for (int s = 0; s < nr; s++)
            send_item(bda_pkg::OP_REQUEST, p, order[s][2:0],
                      16'($urandom_range(0, max_val)), s == nr - 1);
    endtask

    task automatic load_entry(logic [3:0] p, logic [2:0] r);
        logic [15:0] a;
        a = 16'($urandom_range(0, 12));
        send_item(bda_pkg::OP_WR_ALLOC, p, r, a, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 9) == 0)
            send_item(bda_pkg::OP_WR_MAX, p, r, 16'($urandom_range(0, a)), 1'b0);
        else
            send_item(bda_pkg::OP_WR_MAX, p, r, a + 16'($urandom_range(0, 8)), 1'b0);
    endtask

    // entries read with four processes and three resources in use
    task automatic test_load_all();
        for (int p = 0; p < 4; p++)
            for (int r = 0; r < 3; r++) load_entry(p[3:0], r[2:0]);
        for (int r = 0; r < 8; r++)
            send_item(bda_pkg::OP_WR_AVAIL, 4'd0, r[2:0], 16'($urandom_range(5, 30)),
                      1'b0);
    endtask

    // first resource of processes 4 to 15, for the widest process setting
    task automatic test_load_wide();
        for (int p = 4; p < 16; p++) load_entry(p[3:0], 3'd0);
    endtask

    // resources 3 to 7 of the first two processes, for the widest resource setting
    task automatic test_load_deep();
        for (int p = 0; p < 2; p++)
            for (int r = 3; r < 8; r++) load_entry(p[3:0], r[2:0]);
    endtask

    task automatic test_directed();
        send_item(bda_pkg::OP_CHECK, 4'd0, 3'd0, 16'd0, 1'b0);
        // negative need passes the safety check but denies any request
        send_item(bda_pkg::OP_WR_ALLOC, 4'd3, 3'd2, 16'hFFFF, 1'b0);
        send_item(bda_pkg::OP_WR_MAX, 4'd3, 3'd2, 16'd0, 1'b0);
        send_item(bda_pkg::OP_CHECK, 4'd0, 3'd0, 16'd0, 1'b0);
        send_item(bda_pkg::OP_REQUEST, 4'd3, 3'd2, 16'd1, 1'b1);
        // available at the top, request of all of it
        send_item(bda_pkg::OP_WR_AVAIL, 4'd0, 3'd2, 16'hFFFF, 1'b0);
        send_item(bda_pkg::OP_WR_MAX, 4'd2, 3'd2, 16'hFFFF, 1'b0);
        send_item(bda_pkg::OP_WR_ALLOC, 4'd2, 3'd2, 16'd0, 1'b0);
        send_item(bda_pkg::OP_REQUEST, 4'd2, 3'd2, 16'hFFFF, 1'b1);
        send_item(bda_pkg::OP_WR_ALLOC, 4'd2, 3'd2, 16'd0, 1'b0);
        send_item(bda_pkg::OP_WR_MAX, 4'd2, 3'd2, 16'd3, 1'b0);
        send_item(bda_pkg::OP_WR_AVAIL, 4'd0, 3'd2, 16'd20, 1'b0);
        // zero request, then a small one
        send_item(bda_pkg::OP_REQUEST, 4'd0, 3'd0, 16'd0, 1'b1);
        send_item(bda_pkg::OP_REQUEST, 4'd2, 3'd0, 16'd0, 1'b0);
        send_item(bda_pkg::OP_REQUEST, 4'd2, 3'd2, 16'd2, 1'b1);
        // unknown ops do nothing
        send_item(OP_UNUSED_FIRST, 4'd15, 3'd7, 16'hFFFF, 1'b1);
        send_item(OP_UNUSED_FIRST + 3'd1, 4'd0, 3'd0, 16'h5555, 1'b0);
        send_item(OP_UNUSED_FIRST + 3'd2, 4'd10, 3'd5, 16'hAAAA, 1'b1);
        // starve everything for an unsafe verdict, then restore
        for (int r = 0; r < 3; r++)
            send_item(bda_pkg::OP_WR_AVAIL, 4'd0, r[2:0], 16'd0, 1'b0);
        send_item(bda_pkg::OP_CHECK, 4'd0, 3'd0, 16'd0, 1'b0);
        for (int r = 0; r < 3; r++)
            send_item(bda_pkg::OP_WR_AVAIL, 4'd0, r[2:0], 16'd40, 1'b0);
        send_item(bda_pkg::OP_CHECK, 4'd0, 3'd0, 16'd0, 1'b0);
    endtask

    task automatic test_random(int n_items);
        int sent, pick;
        logic [3:0] p;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                if ($urandom_range(0, 4) == 0) p = 4'($urandom_range(0, 15));
                else p = 4'($urandom_range(0, procs_eff() - 1));
                send_request(p, ($urandom_range(0, 9) == 0) ? 65535 : 4);
                sent += res_eff();
            end else if (pick < 60) begin
                send_item(bda_pkg::OP_CHECK, 4'($urandom_range(0, 15)),
                          3'($urandom_range(0, 7)), 16'($urandom),
                          1'($urandom_range(0, 1)));
                sent++;
            end else if (pick < 85) begin
                load_entry(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
                sent += 2;
            end else if (pick < 93) begin
                send_item(bda_pkg::OP_WR_AVAIL, 4'($urandom_range(0, 15)),
                          3'($urandom_range(0, 7)),
                          ($urandom_range(0, 7) == 0) ? 16'hFFFF
                                                      : 16'($urandom_range(0, 40)),
                          1'b0);
                sent++;
            end else begin
                // noise: unknown op or a stray element carried into the next vector
                if (pick < 97) send_item(3'($urandom_range(5, 7)), 4'($urandom),
                                         3'($urandom), 16'($urandom), 1'($urandom));
                else send_item(bda_pkg::OP_REQUEST, 4'($urandom), 3'($urandom),
                               16'($urandom_range(0, 3)), 1'b0);
                sent++;
            end
        end
    endtask

    task automatic test_backpressure();
        wait_idle();
        hold_request = 1;
        for (int i = 0; i < 8; i++) begin
            send_item(bda_pkg::OP_CHECK, 4'd0, 3'd0, 16'd0, 1'b0);
            send_request(4'($urandom_range(0, procs_eff() - 1)), 3);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        write_reg(bda_pkg::CFG_PROCS_IN_USE, 5'd4);
        write_reg(bda_pkg::CFG_RESOURCES_IN_USE, 5'd3);
        test_load_all();
        test_directed();
        test_random(40);
        write_reg(bda_pkg::CFG_PROCS_IN_USE, 5'd1);
        write_reg(bda_pkg::CFG_RESOURCES_IN_USE, 5'd1);
        test_random(20);
        write_reg(bda_pkg::CFG_PROCS_IN_USE, 5'd0);
        write_reg(bda_pkg::CFG_RESOURCES_IN_USE, 5'd0);
        test_random(15);
        test_load_wide();
        write_reg(bda_pkg::CFG_PROCS_IN_USE, 5'd31);
        write_reg(bda_pkg::CFG_RESOURCES_IN_USE, 5'd1);
        test_random(20);
        test_load_deep();
        write_reg(bda_pkg::CFG_PROCS_IN_USE, 5'd2);
        write_reg(bda_pkg::CFG_RESOURCES_IN_USE, 5'd15);
        test_random(20);
        write_reg(bda_pkg::CFG_PROCS_IN_USE, 5'd4);
        write_reg(bda_pkg::CFG_RESOURCES_IN_USE, 5'd3);
        test_backpressure();
        write_reg(bda_pkg::CFG_PROCS_IN_USE, 5'd3);
        test_random(15);
        wait_idle();
        repeat (50) @(posedge aclk);
        if (!failed) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
